[hdl/uer_pkg.sv]
package uer_pkg;

	localparam int COUNTER_BITS_DEF = 16;
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;
	localparam int DIST_W = 10;

	localparam logic [2:0] REG_WAIT_TIMEOUT = 3'd0;
	localparam logic [2:0] REG_ECHO_TIMEOUT = 3'd1;
	localparam logic [2:0] REG_TICKS_PER_CM = 3'd2;
	localparam logic [2:0] REG_PRE_LOW      = 3'd3;
	localparam logic [2:0] REG_HIGH         = 3'd4;

	localparam logic [15:0] WAIT_TIMEOUT_RST = 16'd60000;
	localparam logic [15:0] ECHO_TIMEOUT_RST = 16'd60000;
	localparam logic [7:0]  TICKS_PER_CM_RST = 8'd116;
	localparam logic [7:0]  PRE_LOW_RST      = 8'd4;
	localparam logic [7:0]  HIGH_RST         = 8'd20;

	typedef struct packed {
		logic start_req;
		logic echo_level;
	} req_word_t;

	typedef struct packed {
		logic              trigger_level;
		logic              busy_res;
		logic              done_res;
		logic              valid_res;
		logic [DIST_W-1:0] distance_cm;
	} rsp_word_t;

	typedef struct packed {
		logic [15:0] wait_timeout_ticks;
		logic [15:0] echo_timeout_ticks;
		logic [7:0]  ticks_per_cm;
		logic [7:0]  trigger_pre_low_ticks;
		logic [7:0]  trigger_high_ticks;
	} cfg_t;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_WAIT_LOW,
		PH_PRE_LOW,
		PH_PULSE,
		PH_WAIT_HI,
		PH_MEASURE
	} phase_t;

	typedef enum logic {
		CS_RUN,
		CS_DIV
	} ctl_state_t;

	typedef enum logic [1:0] {
		CNT_HOLD,
		CNT_CLEAR,
		CNT_INC
	} cnt_cmd_t;

	typedef struct packed {
		cnt_cmd_t cnt_cmd;
		logic     res_load;
		logic     res_trig;
		logic     res_busy;
		logic     res_done;
		logic     div_start;
		logic     div_load;
	} dp_cmd_t;

	typedef struct packed {
		logic hit_wait;
		logic hit_pre;
		logic hit_high;
		logic meas_stop;
		logic cnt_zero;
		logic pre_zero;
		logic div_done;
	} dp_status_t;

endpackage

[hdl/ultrasonic_echo_ranger.sv]
// Channel   Direction  Word        Handshake
// req       in         req_word_t  req_valid / req_stall
// rsp       out        rsp_word_t  rsp_valid / rsp_stall
// cfg       in         APB write   psel, penable, pwrite, pready
//
// An accepted tick that does not start a divide yields one response word in the cycle after it.
// The tick that ends an echo with a nonzero count starts a restoring divider instead,
// and the response word is loaded from the rounded quotient once the divider is done.
// Reset clears the phase, the tick counter and the response valid; no clearing pass.
// A stalled response blocks new ticks only until it is taken.
module ultrasonic_echo_ranger import uer_pkg::*; #(
	parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  req_word_t         req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output rsp_word_t         rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	cfg_t       cfg;
	dp_cmd_t    cmd;
	dp_status_t st;

	assign pready = 1'b1;

	uer_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	uer_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.start_req  (req.start_req),
		.echo_level (req.echo_level),
		.rsp_stall  (rsp_stall),
		.st         (st),
		.req_stall  (req_stall),
		.rsp_valid  (rsp_valid),
		.cmd        (cmd)
	);

	uer_dp #(
		.COUNTER_BITS (COUNTER_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cmd    (cmd),
		.st     (st),
		.rsp    (rsp)
	);

	a_no_tick_during_div: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |-> st.div_done)
		else $error("tick accepted while divider running");

	a_div_blocks_ticks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> req_stall)
		else $error("ticks not held off after divide start");

	a_dist_only_when_good: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.distance_cm == '0 || (rsp.valid_res && rsp.done_res)))
		else $error("distance without valid measurement");

	a_good_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.valid_res) |-> (rsp.done_res && !rsp.busy_res && !rsp.trigger_level))
		else $error("valid result while measurement still busy");

endmodule

[hdl/uer_regs.sv]
module uer_regs import uer_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output cfg_t              cfg
);

	cfg_t       cfg_q;
	logic [2:0] idx;
	logic       wr_en;

	assign idx   = paddr[4:2];
	assign wr_en = psel & penable & pwrite;
	assign cfg   = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wait_timeout_ticks    <= WAIT_TIMEOUT_RST;
			cfg_q.echo_timeout_ticks    <= ECHO_TIMEOUT_RST;
			cfg_q.ticks_per_cm          <= TICKS_PER_CM_RST;
			cfg_q.trigger_pre_low_ticks <= PRE_LOW_RST;
			cfg_q.trigger_high_ticks    <= HIGH_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_WAIT_TIMEOUT: cfg_q.wait_timeout_ticks    <= pwdata[15:0];
				REG_ECHO_TIMEOUT: cfg_q.echo_timeout_ticks    <= pwdata[15:0];
				REG_TICKS_PER_CM: cfg_q.ticks_per_cm          <= pwdata[7:0];
				REG_PRE_LOW:      cfg_q.trigger_pre_low_ticks <= pwdata[7:0];
				REG_HIGH:         cfg_q.trigger_high_ticks    <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_WAIT_TIMEOUT: prdata = {16'd0, cfg_q.wait_timeout_ticks};
			REG_ECHO_TIMEOUT: prdata = {16'd0, cfg_q.echo_timeout_ticks};
			REG_TICKS_PER_CM: prdata = {24'd0, cfg_q.ticks_per_cm};
			REG_PRE_LOW:      prdata = {24'd0, cfg_q.trigger_pre_low_ticks};
			REG_HIGH:         prdata = {24'd0, cfg_q.trigger_high_ticks};
			default:          prdata = '0;
		endcase
	end

endmodule

[hdl/uer_dp.sv]
module uer_dp import uer_pkg::*; #(
	parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  dp_cmd_t    cmd,
	output dp_status_t st,
	output rsp_word_t  rsp
);

	localparam int CW = (COUNTER_BITS > 16) ? COUNTER_BITS : 16;
	localparam int QW = COUNTER_BITS + 1;
	localparam int SW = $clog2(QW + 1);

	logic [COUNTER_BITS-1:0] cnt_q;
	logic [COUNTER_BITS-1:0] cnt_nxt;
	logic                    cnt_max;
	logic [CW-1:0]           nxt_w;
	logic [CW-1:0]           cnt_w;

	logic [QW-1:0] dvd_q;
	logic [7:0]    rem_q;
	logic [7:0]    dsr_q;
	logic [SW-1:0] step_q;
	logic [7:0]    dsr;
	logic [8:0]    rem_sh;
	logic          q_bit;
	logic [DIST_W-1:0] dist_sat;

	rsp_word_t res_q;

	assign cnt_max = &cnt_q;
	assign cnt_nxt = cnt_max ? cnt_q : cnt_q + 1'b1;
	assign nxt_w   = CW'(cnt_nxt);
	assign cnt_w   = CW'(cnt_q);

	assign st.hit_wait  = (nxt_w >= CW'(cfg.wait_timeout_ticks)) || (&cnt_nxt);
	assign st.hit_pre   = (nxt_w >= CW'(cfg.trigger_pre_low_ticks)) || (&cnt_nxt);
	assign st.hit_high  = (nxt_w >= CW'(cfg.trigger_high_ticks)) || (&cnt_nxt);
	assign st.meas_stop = (cnt_w >= CW'(cfg.echo_timeout_ticks)) || cnt_max;
	assign st.cnt_zero  = (cnt_q == '0);
	assign st.pre_zero  = (cfg.trigger_pre_low_ticks == 8'd0);
	assign st.div_done  = (step_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			unique case (cmd.cnt_cmd)
				CNT_CLEAR: cnt_q <= '0;
				CNT_INC:   cnt_q <= cnt_nxt;
				default:   cnt_q <= cnt_q;
			endcase
		end
	end

	assign dsr    = (cfg.ticks_per_cm == 8'd0) ? 8'd1 : cfg.ticks_per_cm;
	assign rem_sh = {rem_q, dvd_q[QW-1]};
	assign q_bit  = (rem_sh >= {1'b0, dsr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (cmd.div_start) begin
			step_q <= SW'(QW);
		end else if (step_q != '0) begin
			step_q <= step_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			dvd_q <= {1'b0, cnt_q} + QW'(dsr[7:1]);
			dsr_q <= dsr;
			rem_q <= '0;
		end else if (step_q != '0) begin
			dvd_q <= {dvd_q[QW-2:0], q_bit};
			rem_q <= q_bit ? 8'(rem_sh - {1'b0, dsr_q}) : rem_sh[7:0];
		end
	end

	assign dist_sat = (|dvd_q[QW-1:DIST_W]) ? {DIST_W{1'b1}} : dvd_q[DIST_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			res_q.trigger_level <= 1'b0;
			res_q.busy_res      <= 1'b0;
			res_q.done_res      <= 1'b1;
			res_q.valid_res     <= 1'b1;
			res_q.distance_cm   <= dist_sat;
		end else if (cmd.res_load) begin
			res_q.trigger_level <= cmd.res_trig;
			res_q.busy_res      <= cmd.res_busy;
			res_q.done_res      <= cmd.res_done;
			res_q.valid_res     <= 1'b0;
			res_q.distance_cm   <= '0;
		end
	end

	assign rsp = res_q;

endmodule

[hdl/uer_ctrl.sv]
module uer_ctrl import uer_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  logic       start_req,
	input  logic       echo_level,
	input  logic       rsp_stall,
	input  dp_status_t st,
	output logic       req_stall,
	output logic       rsp_valid,
	output dp_cmd_t    cmd
);

	phase_t     phase_q, phase_d;
	ctl_state_t cs_q, cs_d;
	logic       rsp_valid_q;
	logic       accept;
	logic       done;
	logic       measured;

	assign req_stall = !((cs_q == CS_RUN) && (!rsp_valid_q || !rsp_stall));
	assign accept    = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			cs_q        <= CS_RUN;
			rsp_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			cs_q    <= cs_d;
			if (cmd.res_load || cmd.div_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Decode of one tick: whether it ends the measurement, and with a count to convert.
	always_comb begin
		done     = 1'b0;
		measured = 1'b0;
		unique case (phase_q)
			PH_WAIT_LOW: done = echo_level && st.hit_wait;
			PH_WAIT_HI:  done = !echo_level && st.hit_wait;
			PH_MEASURE: begin
				done     = !echo_level || st.meas_stop;
				measured = !echo_level && !st.cnt_zero;
			end
			default: ;
		endcase
	end

	always_comb begin
		phase_d = phase_q;
		cs_d    = cs_q;
		if (cs_q == CS_DIV) begin
			if (st.div_done) begin
				cs_d = CS_RUN;
			end
		end else if (accept) begin
			if (done) begin
				phase_d = PH_IDLE;
				if (measured) begin
					cs_d = CS_DIV;
				end
			end else begin
				unique case (phase_q)
					PH_IDLE: begin
						if (start_req) begin
							phase_d = PH_WAIT_LOW;
						end
					end
					PH_WAIT_LOW: begin
						if (!echo_level) begin
							phase_d = st.pre_zero ? PH_PULSE : PH_PRE_LOW;
						end
					end
					PH_PRE_LOW: begin
						if (st.hit_pre) begin
							phase_d = PH_PULSE;
						end
					end
					PH_PULSE: begin
						if (st.hit_high) begin
							phase_d = PH_WAIT_HI;
						end
					end
					PH_WAIT_HI: begin
						if (echo_level) begin
							phase_d = PH_MEASURE;
						end
					end
					PH_MEASURE: phase_d = PH_MEASURE;
					default:    phase_d = PH_IDLE;
				endcase
			end
		end
	end

	always_comb begin
		cmd          = '0;
		cmd.cnt_cmd  = CNT_HOLD;
		cmd.div_load = (cs_q == CS_DIV) && st.div_done;
		if (accept) begin
			cmd.res_load  = !measured;
			cmd.div_start = measured;
			cmd.res_trig  = (phase_q == PH_PULSE);
			cmd.res_busy  = (phase_d != PH_IDLE);
			cmd.res_done  = done;
			if (done || phase_d != phase_q) begin
				cmd.cnt_cmd = CNT_CLEAR;
			end else if (phase_q != PH_IDLE) begin
				cmd.cnt_cmd = CNT_INC;
			end
		end
	end

endmodule

[tb/echo_range_checker.sv]
module echo_range_checker import uer_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic              req_stall,
	input  req_word_t         req,
	input  logic              rsp_valid,
	input  logic              rsp_stall,
	input  rsp_word_t         rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output int                mismatches,
	output int                outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned COUNT_TOP = (1 << COUNTER_BITS_DEF) - 1;
	localparam int unsigned DIST_TOP = (1 << DIST_W) - 1;

	cfg_t        settings;
	phase_t      phase;
	int unsigned ticks;
	rsp_word_t   readings_due[$];
	int          errs;
	int          words_seen;

	function automatic logic count_tick(int unsigned limit);
		if (ticks < COUNT_TOP)
			ticks++;
		return ticks >= limit || ticks >= COUNT_TOP;
	endfunction

	function automatic rsp_word_t next_reading(req_word_t w);
		rsp_word_t   r;
		logic        fin;
		int unsigned d;
		int unsigned q;
		r = '0;
		fin = 1'b0;
		case (phase)
			PH_IDLE: begin
				if (w.start_req) begin
					phase = PH_WAIT_LOW;
					ticks = 0;
				end
			end
			PH_WAIT_LOW: begin
				if (!w.echo_level) begin
					ticks = 0;
					phase = (settings.trigger_pre_low_ticks == 0) ? PH_PULSE : PH_PRE_LOW;
				end else if (count_tick(settings.wait_timeout_ticks)) begin
					fin = 1'b1;
				end
			end
			PH_PRE_LOW: begin
				if (count_tick(settings.trigger_pre_low_ticks)) begin
					phase = PH_PULSE;
					ticks = 0;
				end
			end
			PH_PULSE: begin
				r.trigger_level = 1'b1;
				if (count_tick(settings.trigger_high_ticks)) begin
					phase = PH_WAIT_HI;
					ticks = 0;
				end
			end
			PH_WAIT_HI: begin
				if (w.echo_level) begin
					phase = PH_MEASURE;
					ticks = 0;
				end else if (count_tick(settings.wait_timeout_ticks)) begin
					fin = 1'b1;
				end
			end
			PH_MEASURE: begin
				if (w.echo_level) begin
					if (ticks >= settings.echo_timeout_ticks || ticks >= COUNT_TOP)
						fin = 1'b1;
					else
						ticks++;
				end else begin
					fin = 1'b1;
					if (ticks != 0) begin
						d = (settings.ticks_per_cm == 0) ? 1 : settings.ticks_per_cm;
						q = (ticks + d / 2) / d;
						if (q > DIST_TOP)
							q = DIST_TOP;
						r.valid_res = 1'b1;
						r.distance_cm = DIST_W'(q);
					end
				end
			end
			default: begin
				phase = PH_IDLE;
				ticks = 0;
			end
		endcase
		if (fin) begin
			phase = PH_IDLE;
			ticks = 0;
		end
		r.busy_res = (phase != PH_IDLE);
		r.done_res = fin;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		rsp_word_t due;
		if (!arst_n) begin
			settings = {WAIT_TIMEOUT_RST, ECHO_TIMEOUT_RST, TICKS_PER_CM_RST, PRE_LOW_RST,
				HIGH_RST};
			phase = PH_IDLE;
			ticks = 0;
			readings_due.delete();
			errs = 0;
			words_seen = 0;
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				words_seen++;
				if (readings_due.size() == 0) begin
					errs++;
					if (errs <= 10)
						$display("response word %0d arrived with none expected: %h",
							words_seen, rsp);
				end else begin
					due = readings_due.pop_front();
					if (rsp.trigger_level !== due.trigger_level ||
						rsp.busy_res !== due.busy_res ||
						rsp.done_res !== due.done_res ||
						rsp.valid_res !== due.valid_res ||
						rsp.distance_cm !== due.distance_cm) begin
						errs++;
						if (errs <= 10)
							$display({"response word %0d: expected trig %b busy %b done %b ",
								"valid %b dist %0d, got trig %b busy %b done %b valid %b dist %0d"},
								words_seen, due.trigger_level, due.busy_res, due.done_res,
								due.valid_res, due.distance_cm, rsp.trigger_level, rsp.busy_res,
								rsp.done_res, rsp.valid_res, rsp.distance_cm);
					end
				end
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_W-1:2])
					REG_WAIT_TIMEOUT: settings.wait_timeout_ticks = pwdata[15:0];
					REG_ECHO_TIMEOUT: settings.echo_timeout_ticks = pwdata[15:0];
					REG_TICKS_PER_CM: settings.ticks_per_cm = pwdata[7:0];
					REG_PRE_LOW:      settings.trigger_pre_low_ticks = pwdata[7:0];
					REG_HIGH:         settings.trigger_high_ticks = pwdata[7:0];
					default: ;
				endcase
			end
			if (req_valid && !req_stall)
				readings_due.push_back(next_reading(req));
			mismatches <= errs;
			outstanding <= readings_due.size();
		end
	end

endmodule

[tb/ultrasonic_echo_ranger_tb.sv]
module ultrasonic_echo_ranger_tb import uer_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned RUN_LIMIT = 2_000_000;
	localparam logic [2:0] REG_UNUSED = 3'd5;

	logic              clk;
	logic              arst_n;
	logic              req_valid;
	logic              req_stall;
	req_word_t         req;
	logic              rsp_valid;
	logic              rsp_stall;
	rsp_word_t         rsp;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	int          mismatches;
	int          outstanding;
	bit          quiet;
	bit          long_hold;
	int unsigned cur_wait;
	int unsigned cur_echo;
	int unsigned cur_pre;
	int unsigned cur_high;
	int          burst_left;
	int          items;
	int unsigned cycle_count;

	ultrasonic_echo_ranger dut (.*);

	echo_range_checker scoreboard (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.rsp         (rsp),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < RUN_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		int stretch;
		int style;
		rsp_stall <= 1'b0;
		stretch = 0;
		style = 0;
		forever begin
			@(posedge clk);
			if (long_hold) begin
				rsp_stall <= 1'b1;
				repeat (300) @(posedge clk);
				long_hold = 1'b0;
				rsp_stall <= 1'b0;
			end else if (quiet) begin
				rsp_stall <= 1'b0;
			end else begin
				if (stretch == 0) begin
					style = $urandom_range(0, 2);
					stretch = $urandom_range(4, 40);
				end
				stretch--;
				case (style)
					0: rsp_stall <= 1'b0;
					1: rsp_stall <= ($urandom_range(0, 1) == 1);
					default: rsp_stall <= ($urandom_range(0, 3) != 0);
				endcase
			end
		end
	end

	task automatic put_word(logic s, logic e);
		req_word_t w;
		if (burst_left == 0) begin
			if (!quiet) begin
				req_valid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		w.start_req = s;
		w.echo_level = e;
		req <= w;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		items++;
	endtask

	task automatic halt_words();
		req_valid <= 1'b0;
		burst_left = 0;
	endtask

	task automatic settle();
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(int unsigned w, int unsigned e, int unsigned t, int unsigned pr,
		int unsigned hi);
		write_reg(REG_WAIT_TIMEOUT, w);
		write_reg(REG_ECHO_TIMEOUT, e);
		write_reg(REG_TICKS_PER_CM, t);
		write_reg(REG_PRE_LOW, pr);
		write_reg(REG_HIGH, hi);
		cur_wait = w;
		cur_echo = e;
		cur_pre = pr;
		cur_high = hi;
	endtask

	function automatic logic stray_start();
		return ($urandom_range(0, 3) == 0);
	endfunction

	// The echo is don't-care while the trigger is being driven, so it is random there.
	task automatic measure(int lead, int lull, int pulse);
		int trig_ticks;
		trig_ticks = cur_pre + ((cur_high == 0) ? 1 : cur_high);
		put_word(1'b1, 1'($urandom_range(0, 1)));
		repeat (lead) put_word(stray_start(), 1'b1);
		put_word(stray_start(), 1'b0);
		repeat (trig_ticks) put_word(stray_start(), 1'($urandom_range(0, 1)));
		repeat (lull) put_word(stray_start(), 1'b0);
		repeat (pulse) put_word(stray_start(), 1'b1);
		put_word(stray_start(), 1'b0);
	endtask

	task automatic random_measurement();
		int kind;
		int lead;
		int lull;
		int pulse;
		int wt;
		wt = (cur_wait == 0) ? 1 : cur_wait;
		kind = $urandom_range(0, 19);
		lead = 0;
		lull = 0;
		if (kind < 14) begin
			if (wt > 1 && $urandom_range(0, 2) == 0)
				lead = $urandom_range(1, wt - 1);
			if (wt > 1)
				lull = $urandom_range(0, wt - 1);
			case ($urandom_range(0, 9))
				0: pulse = 1;
				1: pulse = cur_echo + $urandom_range(2, 3);
				default: pulse = $urandom_range(2, cur_echo + 1);
			endcase
			measure(lead, lull, pulse);
		end else if (kind < 17) begin
			measure(wt + $urandom_range(0, 2), 0, 0);
		end else if (kind < 19) begin
			measure(0, wt + $urandom_range(0, 2), 0);
		end else begin
			repeat ($urandom_range(1, 8))
				put_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		end
	endtask

	initial begin
		int unsigned t;
		int base;
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		quiet = 1'b0;
		long_hold = 1'b0;
		burst_left = 0;
		items = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_config(2, 3, 0, 0, 0);
		write_reg(REG_UNUSED, 32'hFFFF_FFFF);
		put_word(1'b0, 1'b0);
		put_word(1'b1, 1'b1);
		repeat (2) put_word(1'b0, 1'b1);
		put_word(1'b1, 1'b0);
		put_word(1'b0, 1'b0);
		put_word(1'b1, 1'b1);
		repeat (4) put_word(1'b0, 1'b1);
		put_word(1'b1, 1'b1);
		put_word(1'b1, 1'b0);
		repeat (2) put_word(1'b0, 1'b0);
		put_word(1'b0, 1'b1);
		put_word(1'b0, 1'b0);
		put_word(1'b1, 1'b0);
		repeat (2) put_word(1'b0, 1'b0);
		repeat (2) put_word(1'b0, 1'b1);
		put_word(1'b0, 1'b0);
		put_word(1'b1, 1'b0);
		repeat (4) put_word(1'b0, 1'b0);
		halt_words();

		settle();
		quiet = 1'b1;
		set_config(65535, 65535, 1, 1, 1);
		measure(0, 0, 60);
		halt_words();
		settle();
		quiet = 1'b0;

		for (int p = 0; p < 6; p++) begin
			t = (p == 0) ? 1 : (p == 1) ? 255 : (p == 2) ? 0 : $urandom_range(2, 40);
			set_config((p == 3) ? 0 : $urandom_range(1, 12), (p == 4) ? 0 : $urandom_range(1, 48),
				t, (p == 1) ? 0 : $urandom_range(0, 5), (p == 2) ? 0 : $urandom_range(0, 5));
			if (p == 1)
				long_hold = 1'b1;
			base = items;
			while (items - base < 95)
				random_measurement();
			halt_words();
			settle();
		end

		if (mismatches == 0 && outstanding == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
